FILE: rtl/srpg_pkg.sv
// Shared types, codes, constants and period helpers for the step pulse generator.
package srpg_pkg;

   // Command codes carried in the func field; the fourth code is a no-op
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_STOP  = 2'd2
   } func_type;

   localparam int          FRAC_BITS    = 24;  // Q40.24 ramp product scaling
   localparam int          TERM_BITS    = 40;
   localparam int          RAMP_BITS    = 32;
   localparam int          ELAPSED_BITS = 48;
   localparam logic [31:0] PERIOD_MAX   = 32'hFFFF_FFFF;

   // One input beat
   typedef struct packed {
      logic [1:0]         func;
      logic [31:0]        move_steps;
      logic signed [24:0] signed_period;
      logic [31:0]        ramp_steps;
      logic [31:0]        ramp_slope;
   } req_type;

   // One result beat
   typedef struct packed {
      logic        step_level;
      logic        dir_ccw;
      logic        running;
      logic [31:0] steps_left_out;
      logic [47:0] elapsed_us;
      logic        start_ignored;
   } rsp_type;

   // Registered ramp product for the next falling edge
   typedef struct packed {
      logic        on_ramp;
      logic [63:0] product;
   } ramp_type;

   // floor(product / 2^24) plus goal, saturated to 32 bits
   function automatic logic [31:0] sat_period(input logic [TERM_BITS-1:0] term,
                                              input logic [31:0] goal);
      logic [TERM_BITS:0] sum;
      sum = {1'b0, term} + (TERM_BITS+1)'(goal);
      if (sum > (TERM_BITS+1)'(PERIOD_MAX))
         return PERIOD_MAX;
      return sum[31:0];
   endfunction

   // Alarm interval: half the period, never below one tick
   function automatic logic [31:0] half_interval(input logic [31:0] period);
      logic [31:0] h;
      h = period >> 1;
      return (h == 32'd0) ? 32'd1 : h;
   endfunction

endpackage

FILE: rtl/srpg_ramp.sv
// Look-ahead ramp stage: picks the ramp distance and registers distance times slope.
module srpg_ramp #(
   parameter int STEP_COUNT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [STEP_COUNT_BITS-1:0] done_steps,
   input  logic [STEP_COUNT_BITS-1:0] left_steps,
   input  logic [31:0]                ramp_len,
   input  logic [31:0]                slope,
   output srpg_pkg::ramp_type         ramp
);
   import srpg_pkg::*;

   localparam int CW = (STEP_COUNT_BITS > 24) ? STEP_COUNT_BITS : 24;

   logic [CW-1:0] done_w;
   logic [CW-1:0] left_w;
   logic [CW-1:0] limit_w;
   logic          in_up;
   logic          in_down;
   logic [31:0]   ramp_dist;
   ramp_type      ramp_in;
   ramp_type      ramp_ff;

   // n*256 < ramp  <=>  n <= (ramp-1) >> 8, with ramp non-zero
   always_comb begin
      done_w  = CW'(done_steps);
      left_w  = CW'(left_steps);
      limit_w = CW'((ramp_len - 32'd1) >> 8);
      in_up   = (ramp_len != 32'd0) && (done_w <= limit_w);
      in_down = (ramp_len != 32'd0) && (left_w <= limit_w);
   end

   // Up ramp counts from steps done, down ramp from steps left
   always_comb begin
      if (in_up)
         ramp_dist = ramp_len - {done_w[23:0], 8'h00};
      else
         ramp_dist = ramp_len - {left_w[23:0], 8'h00};
      ramp_in.on_ramp = in_up || in_down;
      ramp_in.product = 64'(ramp_dist) * 64'(slope);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff.on_ramp <= 1'b0;
      end else begin
         ramp_ff.on_ramp <= ramp_in.on_ramp;
      end
      ramp_ff.product <= ramp_in.product;
   end

   assign ramp = ramp_ff;

endmodule

FILE: rtl/srpg_ctrl.sv
// Motion state: tick timer, step pin, step counts and per-beat next-state logic.
module srpg_ctrl #(
   parameter int STEP_COUNT_BITS = 32,
   parameter int PERIOD_BITS     = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  srpg_pkg::req_type          req,
   input  srpg_pkg::ramp_type         ramp,
   output srpg_pkg::rsp_type          rsp,
   output logic [STEP_COUNT_BITS-1:0] done_steps,
   output logic [STEP_COUNT_BITS-1:0] left_steps,
   output logic [31:0]                ramp_len,
   output logic [31:0]                slope
);
   import srpg_pkg::*;

   localparam logic [32:0] GOAL_MAX = (33'd1 << PERIOD_BITS) - 33'd1;

   logic                       pin_ff,     pin_in;
   logic                       dir_ff,     dir_in;
   logic                       active_ff,  active_in;
   logic [STEP_COUNT_BITS-1:0] left_ff,    left_in;
   logic [STEP_COUNT_BITS-1:0] done_ff,    done_in;
   logic [PERIOD_BITS-1:0]     goal_ff,    goal_in;
   logic [31:0]                ramp_ff,    ramp_in;
   logic [31:0]                slope_ff,   slope_in;
   logic [31:0]                tick_ff,    tick_in;
   logic [31:0]                alarm_ff,   alarm_in;
   logic [ELAPSED_BITS-1:0]    elapsed_ff, elapsed_in;
   logic                       ignored;

   logic [31:0]                tick_inc;
   logic [31:0]                fall_period;
   logic [STEP_COUNT_BITS-1:0] start_steps;
   logic [25:0]                mag;
   logic [PERIOD_BITS-1:0]     start_goal;
   logic [63:0]                start_prod;
   logic [31:0]                start_period;

   // Period of the step now ending, from the look-ahead product
   always_comb begin
      tick_inc = tick_ff + 32'd1;
      if (ramp.on_ramp)
         fall_period = sat_period(ramp.product[63:FRAC_BITS], 32'(goal_ff));
      else
         fall_period = 32'(goal_ff);
   end

   // Start command decode: goal magnitude and first period
   always_comb begin
      start_steps = STEP_COUNT_BITS'(req.move_steps);
      if (req.signed_period[24])
         mag = 26'h200_0000 - {1'b0, req.signed_period};
      else
         mag = {1'b0, req.signed_period};
      if (33'(mag) > GOAL_MAX)
         start_goal = PERIOD_BITS'(GOAL_MAX);
      else
         start_goal = PERIOD_BITS'(mag);
      start_prod   = 64'(req.ramp_steps) * 64'(req.ramp_slope);
      start_period = sat_period(start_prod[63:FRAC_BITS], 32'(start_goal));
   end

   // Next state for the beat being executed
   always_comb begin
      pin_in     = pin_ff;
      dir_in     = dir_ff;
      active_in  = active_ff;
      left_in    = left_ff;
      done_in    = done_ff;
      goal_in    = goal_ff;
      ramp_in    = ramp_ff;
      slope_in   = slope_ff;
      tick_in    = tick_ff;
      alarm_in   = alarm_ff;
      elapsed_in = elapsed_ff;
      ignored    = 1'b0;
      if (fire) begin
         case (func_type'(req.func))
            FUNC_TICK: begin
               if (active_ff) begin
                  if (tick_inc >= alarm_ff) begin
                     tick_in = 32'd0;
                     if (left_ff == '0) begin
                        active_in = 1'b0;
                     end else if (pin_ff) begin
                        // falling edge: one step issued, next period set
                        alarm_in   = half_interval(fall_period);
                        elapsed_in = elapsed_ff + ELAPSED_BITS'(fall_period);
                        left_in    = left_ff - STEP_COUNT_BITS'(1);
                        done_in    = done_ff + STEP_COUNT_BITS'(1);
                        pin_in     = 1'b0;
                     end else begin
                        pin_in = 1'b1;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
            FUNC_START: begin
               if (active_ff) begin
                  ignored = 1'b1;
               end else if (start_steps != '0) begin
                  dir_in     = ~req.signed_period[24];
                  goal_in    = start_goal;
                  ramp_in    = req.ramp_steps;
                  slope_in   = req.ramp_slope;
                  left_in    = start_steps;
                  done_in    = '0;
                  elapsed_in = ELAPSED_BITS'(start_period);
                  alarm_in   = half_interval(start_period);
                  tick_in    = 32'd0;
                  active_in  = 1'b1;
               end
            end
            FUNC_STOP: begin
               active_in = 1'b0;
               pin_in    = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff     <= 1'b0;
         dir_ff     <= 1'b0;
         active_ff  <= 1'b0;
         left_ff    <= '0;
         done_ff    <= '0;
         goal_ff    <= '0;
         ramp_ff    <= 32'd0;
         slope_ff   <= 32'd0;
         tick_ff    <= 32'd0;
         alarm_ff   <= 32'd1;
         elapsed_ff <= '0;
      end else begin
         pin_ff     <= pin_in;
         dir_ff     <= dir_in;
         active_ff  <= active_in;
         left_ff    <= left_in;
         done_ff    <= done_in;
         goal_ff    <= goal_in;
         ramp_ff    <= ramp_in;
         slope_ff   <= slope_in;
         tick_ff    <= tick_in;
         alarm_ff   <= alarm_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Result reflects the state after this beat
   always_comb begin
      rsp.step_level     = pin_in;
      rsp.dir_ccw        = dir_in;
      rsp.running        = active_in;
      rsp.steps_left_out = 32'(left_in);
      rsp.elapsed_us     = elapsed_in;
      rsp.start_ignored  = ignored;
   end

   assign done_steps = done_ff;
   assign left_steps = left_ff;
   assign ramp_len   = ramp_ff;
   assign slope      = slope_ff;

endmodule

FILE: rtl/stepper_ramp_pulse_generator.sv
// Top level: input register, motion state, ramp look-ahead and result register.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    func, move_steps, signed_period, ramp_steps/slope
//   rsp      out        rsp_valid/stall    step_level, dir_ccw, running, steps_left_out,
//                                          elapsed_us, start_ignored
//
// One beat per cycle sustained while rsp is not stalled; a beat's result passes through
// the input register, then the state update into the result register.
// The next falling-edge period is multiplied ahead and registered from the held state; a
// falling edge is always at least two beats after the state it depends on last changed.
// Reset (synchronous) clears valid and motion state, alarm interval to one tick; not payloads.
// An rsp stall holds the result register; req stalls only once the input register also holds.
module stepper_ramp_pulse_generator #(
   parameter int STEP_COUNT_BITS = 32,
   parameter int PERIOD_BITS     = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [31:0]        req_move_steps,
   input  logic signed [24:0] req_signed_period,
   input  logic [31:0]        req_ramp_steps,
   input  logic [31:0]        req_ramp_slope,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_step_level,
   output logic               rsp_dir_ccw,
   output logic               rsp_running,
   output logic [31:0]        rsp_steps_left_out,
   output logic [47:0]        rsp_elapsed_us,
   output logic               rsp_start_ignored
);
   import srpg_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   req_type                    in_beat_ff;
   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_beat_ff;
   rsp_type                    rsp_next;
   ramp_type                   ramp;
   logic                       advance;
   logic                       load;
   logic [STEP_COUNT_BITS-1:0] done_steps;
   logic [STEP_COUNT_BITS-1:0] left_steps;
   logic [31:0]                ramp_len;
   logic [31:0]                slope;

   // Handshake: execute when the result register is free or being emptied
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      load         = req_valid && !req_stall;
      in_valid_in  = load || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         in_beat_ff.func          <= req_func;
         in_beat_ff.move_steps    <= req_move_steps;
         in_beat_ff.signed_period <= req_signed_period;
         in_beat_ff.ramp_steps    <= req_ramp_steps;
         in_beat_ff.ramp_slope    <= req_ramp_slope;
      end
      if (advance)
         out_beat_ff <= rsp_next;
   end

   srpg_ctrl #(
      .STEP_COUNT_BITS (STEP_COUNT_BITS),
      .PERIOD_BITS     (PERIOD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .req        (in_beat_ff),
      .ramp       (ramp),
      .rsp        (rsp_next),
      .done_steps (done_steps),
      .left_steps (left_steps),
      .ramp_len   (ramp_len),
      .slope      (slope)
   );

   srpg_ramp #(
      .STEP_COUNT_BITS (STEP_COUNT_BITS)
   ) u_ramp (
      .clock      (clock),
      .reset      (reset),
      .done_steps (done_steps),
      .left_steps (left_steps),
      .ramp_len   (ramp_len),
      .slope      (slope),
      .ramp       (ramp)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_step_level     = out_beat_ff.step_level;
   assign rsp_dir_ccw        = out_beat_ff.dir_ccw;
   assign rsp_running        = out_beat_ff.running;
   assign rsp_steps_left_out = out_beat_ff.steps_left_out;
   assign rsp_elapsed_us     = out_beat_ff.elapsed_us;
   assign rsp_start_ignored  = out_beat_ff.start_ignored;

endmodule
